### src/in_list_row_filter_macros.svh
// Assertion macros used by the in-list row filter RTL.
`ifndef IN_LIST_ROW_FILTER_MACROS_SVH
`define IN_LIST_ROW_FILTER_MACROS_SVH

// Checked only while out of reset.
`define ILRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ILRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/ilrf_pkg.sv
// Types and constants of the in-list row filter.
`timescale 1ns / 1ps

package ilrf_pkg;

  localparam int unsigned ROW_W  = 16;
  localparam int unsigned KEPT_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [KEPT_W-1:0] KEPT_MAX = 17'd65536;

  typedef enum logic [1:0] {
    ITEM_EVAL  = 2'd0,
    ITEM_ADD   = 2'd1,
    ITEM_CLEAR = 2'd2
  } ilrf_mode_e;

  typedef enum logic [1:0] {
    COMB_COMPACT = 2'd0,
    COMB_OR      = 2'd1,
    COMB_AND     = 2'd2
  } ilrf_comb_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIST_KIND    = 2'd0,
    REG_NEGATE       = 2'd1,
    REG_COMBINE_MODE = 2'd2
  } ilrf_reg_e;

  typedef struct packed {
    logic       list_kind;
    logic       negate;
    logic [1:0] combine_mode;
  } ilrf_cfg_t;

  // Row item minus the key, which lives at its own width.
  typedef struct packed {
    logic [1:0]       mode;
    logic             is_null;
    logic [ROW_W-1:0] row_index;
    logic             prior_flag;
    logic             last_row;
  } ilrf_item_t;

  typedef struct packed {
    logic add;
    logic clear;
  } ilrf_set_cmd_t;

  typedef struct packed {
    logic              found;
    logic              full;
  } ilrf_set_stat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic              passed;
    logic              flag;
    logic [ROW_W-1:0]  slot;
    logic [KEPT_W-1:0] kept_total;
    logic              last;
    logic              set_full;
  } ilrf_result_t;

endpackage

### src/in_list_row_filter.sv
// Top level of the IN / NOT IN row filter.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries add, clear and evaluate
//   items; a transfer happens when valid is high and stall is low. The
//   output channel (out_valid_o / out_stall_i) returns one result for each
//   add, clear or evaluate item; the unused item code gives no result.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
//   while the block is idle.
// Path: an accepted item sits in the input register, and its result is then
//   registered in the output register, from which it can transfer.
// Throughput: one item per cycle while the output is not stalled; the set
//   lookup is a parallel compare of the input-register key against all
//   stored entries, and set updates land in time for the item right behind.
// Reset: set emptied (valid bits and fill cleared), kept count zero,
//   registers back to IN list, no negate, compact mode; both stages empty.
// Stall: while out_stall_i holds a waiting result, the input register
//   keeps its item and in_stall_o rises once that register is occupied.
`timescale 1ns / 1ps

module in_list_row_filter #(
  parameter int unsigned SET_DEPTH = 16,
  parameter int unsigned KEY_BITS  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ilrf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ilrf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [63:0]                         key_value_i,
  input  logic                                is_null_i,
  input  logic [ilrf_pkg::ROW_W-1:0]          row_index_i,
  input  logic                                prior_flag_i,
  input  logic                                last_row_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ilrf_pkg::ROW_W-1:0]          row_index_out_o,
  output logic                                passed_o,
  output logic                                flag_out_o,
  output logic [ilrf_pkg::ROW_W-1:0]          slot_o,
  output logic [ilrf_pkg::KEPT_W-1:0]         kept_total_o,
  output logic                                last_out_o,
  output logic                                set_full_o
);
  import ilrf_pkg::*;

  ilrf_cfg_t         cfg_q;
  logic              s1_valid_q;
  ilrf_item_t        s1_item_q;
  logic [KEY_BITS-1:0] s1_key_q;
  logic              out_valid_q;
  ilrf_result_t      res_q;
  logic [KEPT_W-1:0] kept_q, kept_d;

  logic           s2_ready, s1_adv, in_xfer, res_valid;
  ilrf_set_cmd_t  cmd;
  ilrf_set_stat_t stat;
  ilrf_result_t   res_d;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LIST_KIND:    cfg_q.list_kind    <= cfg_data_i[0];
        REG_NEGATE:       cfg_q.negate       <= cfg_data_i[0];
        REG_COMBINE_MODE: cfg_q.combine_mode <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kept_q      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_ready) begin
        out_valid_q <= s1_adv && res_valid;
      end
      if (s1_adv) begin
        kept_q <= kept_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.mode       <= mode_i;
      s1_item_q.is_null    <= is_null_i;
      s1_item_q.row_index  <= row_index_i;
      s1_item_q.prior_flag <= prior_flag_i;
      s1_item_q.last_row   <= last_row_i;
      s1_key_q             <= key_value_i[KEY_BITS-1:0];
    end
    if (s1_adv && res_valid) begin
      res_q <= res_d;
    end
  end

  ilrf_set_store #(
    .SET_DEPTH (SET_DEPTH),
    .KEY_BITS  (KEY_BITS)
  ) u_set (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (s1_key_q),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  ilrf_eval u_eval (
    .cfg_i       (cfg_q),
    .item_i      (s1_item_q),
    .adv_i       (s1_adv),
    .stat_i      (stat),
    .kept_i      (kept_q),
    .cmd_o       (cmd),
    .res_valid_o (res_valid),
    .res_o       (res_d),
    .kept_d_o    (kept_d)
  );

  assign out_valid_o     = out_valid_q;
  assign row_index_out_o = res_q.row_index;
  assign passed_o        = res_q.passed;
  assign flag_out_o      = res_q.flag;
  assign slot_o          = res_q.slot;
  assign kept_total_o    = res_q.kept_total;
  assign last_out_o      = res_q.last;
  assign set_full_o      = res_q.set_full;

endmodule

### src/ilrf_set_store.sv
// Value set: stored keys, valid bits, fill count and parallel lookup.
`timescale 1ns / 1ps

`include "in_list_row_filter_macros.svh"

module ilrf_set_store #(
  parameter int unsigned SET_DEPTH = 16,
  parameter int unsigned KEY_BITS  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [KEY_BITS-1:0]   key_i,
  input  ilrf_pkg::ilrf_set_cmd_t  cmd_i,
  output ilrf_pkg::ilrf_set_stat_t stat_o
);
  import ilrf_pkg::*;

  localparam int unsigned IDX_W  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(SET_DEPTH + 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SET_DEPTH);

  logic [KEY_BITS-1:0] values_q [SET_DEPTH];
  logic [SET_DEPTH-1:0] valid_q, valid_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [SET_DEPTH-1:0] hit;
  logic                 found, full, wr_en;
  logic [IDX_W-1:0]     wr_idx;

  always_comb begin
    for (int k = 0; k < SET_DEPTH; k++) begin
      hit[k] = valid_q[k] && (values_q[k] == key_i);
    end
  end

  assign found  = |hit;
  assign full   = (fill_q == FULL_FILL);
  assign wr_idx = fill_q[IDX_W-1:0];
  // Duplicates are ignored; a full set drops the key.
  assign wr_en  = cmd_i.add && !found && !full;

  assign stat_o.found = found;
  assign stat_o.full  = full;

  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    if (cmd_i.clear) begin
      valid_d = '0;
      fill_d  = '0;
    end else if (wr_en) begin
      valid_d[wr_idx] = 1'b1;
      fill_d          = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      values_q[wr_idx] <= key_i;
    end
  end

  `ILRF_ASSERT(a_fill_bound, fill_q <= FULL_FILL, "set fill beyond depth")
  `ILRF_ASSERT(a_valid_fill, $countones(valid_q) == int'(fill_q), "valid bits disagree with fill")
  `ILRF_ASSERT(a_clear_empties, cmd_i.clear |=> (fill_q == '0), "clear left entries")
  `ILRF_ASSERT(a_full_drop, (cmd_i.add && full) |=> $stable(fill_q), "add to full set changed fill")

endmodule

### src/ilrf_eval.sv
// Predicate, merge and compaction logic for the item in the input register.
`timescale 1ns / 1ps

module ilrf_eval (
  input  ilrf_pkg::ilrf_cfg_t              cfg_i,
  input  ilrf_pkg::ilrf_item_t             item_i,
  input  logic                             adv_i,
  input  ilrf_pkg::ilrf_set_stat_t         stat_i,
  input  logic [ilrf_pkg::KEPT_W-1:0]      kept_i,
  output ilrf_pkg::ilrf_set_cmd_t          cmd_o,
  output logic                             res_valid_o,
  output ilrf_pkg::ilrf_result_t           res_o,
  output logic [ilrf_pkg::KEPT_W-1:0]      kept_d_o
);
  import ilrf_pkg::*;

  logic              passed, compact, inc;
  logic [KEPT_W-1:0] kept_sum;

  assign passed  = (!item_i.is_null && (stat_i.found ^ cfg_i.list_kind)) ^ cfg_i.negate;
  // Unused combine code falls back to compaction.
  assign compact = (cfg_i.combine_mode != COMB_OR) && (cfg_i.combine_mode != COMB_AND);
  assign inc      = passed && (kept_i < KEPT_MAX);
  assign kept_sum = kept_i + KEPT_W'(inc);

  always_comb begin
    cmd_o       = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    kept_d_o    = kept_i;
    case (item_i.mode)
      ITEM_EVAL: begin
        res_valid_o     = 1'b1;
        res_o.row_index = item_i.row_index;
        res_o.passed    = passed;
        res_o.last      = item_i.last_row;
        case (cfg_i.combine_mode)
          COMB_OR:  res_o.flag = item_i.prior_flag | passed;
          COMB_AND: res_o.flag = item_i.prior_flag & passed;
          default:  res_o.flag = passed;
        endcase
        if (compact) begin
          res_o.slot       = kept_i[ROW_W-1:0];
          res_o.kept_total = kept_sum;
          kept_d_o         = kept_sum;
        end
        if (item_i.last_row) begin
          kept_d_o = '0;
        end
      end
      ITEM_ADD: begin
        res_valid_o    = 1'b1;
        cmd_o.add      = adv_i;
        res_o.set_full = !stat_i.found && stat_i.full;
      end
      ITEM_CLEAR: begin
        res_valid_o = 1'b1;
        cmd_o.clear = adv_i;
      end
      default: begin
        // Unused item code: consumed without a result.
        res_valid_o = 1'b0;
      end
    endcase
  end

endmodule

### dv/in_list_row_filter_tb.sv
// Self-checking testbench for the IN / NOT IN row filter: random and directed items with a scoreboard.
`timescale 1ns / 1ps

module in_list_row_filter_tb;
  import ilrf_pkg::*;

  localparam int unsigned SET_DEPTH = 16;
  localparam int unsigned KEY_BITS  = 64;

  localparam logic [1:0] ITEM_IGNORED = 2'd3;  // unused item code, gives no result

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_FROM     = 1000;
  localparam int QUIET_TO       = 3000;
  localparam int HOLDOFF_AT     = 200;
  localparam int HOLDOFF_LEN    = 60;
  localparam int PHASE_ITEMS    = 66;
  localparam int BATCH_ROWS     = 24;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0]       mode;
    logic [63:0]      key;
    logic             is_null;
    logic [ROW_W-1:0] row;
    logic             prior;
    logic             last;
  } row_item_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            mode_i       = '0;
  logic [63:0]           key_value_i  = '0;
  logic                  is_null_i    = 1'b0;
  logic [ROW_W-1:0]      row_index_i  = '0;
  logic                  prior_flag_i = 1'b0;
  logic                  last_row_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [ROW_W-1:0]      row_index_out_o;
  logic                  passed_o;
  logic                  flag_out_o;
  logic [ROW_W-1:0]      slot_o;
  logic [KEPT_W-1:0]     kept_total_o;
  logic                  last_out_o;
  logic                  set_full_o;

  in_list_row_filter #(
    .SET_DEPTH(SET_DEPTH),
    .KEY_BITS (KEY_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .key_value_i    (key_value_i),
    .is_null_i      (is_null_i),
    .row_index_i    (row_index_i),
    .prior_flag_i   (prior_flag_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_index_out_o(row_index_out_o),
    .passed_o       (passed_o),
    .flag_out_o     (flag_out_o),
    .slot_o         (slot_o),
    .kept_total_o   (kept_total_o),
    .last_out_o     (last_out_o),
    .set_full_o     (set_full_o)
  );

  // Shadow copy of the filter state and registers
  logic [63:0]       held_key [SET_DEPTH];
  bit                held_valid [SET_DEPTH];
  int unsigned       held_fill = 0;
  logic [KEPT_W-1:0] kept_tally = '0;
  logic              cfg_list_kind = 1'b0;
  logic              cfg_negate = 1'b0;
  logic [1:0]        cfg_comb = COMB_COMPACT;

  row_item_t     pending_items [$];
  ilrf_result_t  expected_results [$];
  logic [63:0]   key_pool [$];

  row_item_t     cur_item = '0;
  row_item_t     next_item;
  ilrf_result_t  predicted;
  ilrf_result_t  got;
  ilrf_result_t  want;
  int            items_taken = 0;
  int            mismatches = 0;
  int            cycle_cnt = 0;
  int            stuck_cycles = 0;
  int            holdoff_left = 0;
  bit            holdoff_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit take_break();
    if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  // Updates the shadow state for one item; returns 0 when the item gives no result.
  function automatic bit predict_filter_result(input row_item_t it, output ilrf_result_t res);
    bit hit;
    bit pass;
    res = '0;
    if (it.mode == ITEM_IGNORED) return 1'b0;
    hit = 1'b0;
    for (int k = 0; k < SET_DEPTH; k++) begin
      if (held_valid[k] && held_key[k] == it.key) hit = 1'b1;
    end
    case (it.mode)
      ITEM_ADD: begin
        if (!hit) begin
          if (held_fill >= SET_DEPTH) begin
            res.set_full = 1'b1;
          end else begin
            held_key[held_fill]   = it.key;
            held_valid[held_fill] = 1'b1;
            held_fill++;
          end
        end
      end
      ITEM_CLEAR: begin
        for (int k = 0; k < SET_DEPTH; k++) held_valid[k] = 1'b0;
        held_fill = 0;
      end
      default: begin
        pass = (!it.is_null && (hit ^ cfg_list_kind)) ^ cfg_negate;
        res.row_index = it.row;
        res.passed    = pass;
        res.last      = it.last;
        case (cfg_comb)
          COMB_OR:  res.flag = it.prior | pass;
          COMB_AND: res.flag = it.prior & pass;
          default: begin
            res.flag = pass;
            res.slot = kept_tally[ROW_W-1:0];
            if (pass && kept_tally < KEPT_MAX) kept_tally++;
            res.kept_total = kept_tally;
          end
        endcase
        if (it.last) kept_tally = '0;
      end
    endcase
    return 1'b1;
  endfunction

  // Sender: one transfer per accepted item, payload held while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (predict_filter_result(cur_item, predicted)) expected_results.push_back(predicted);
        items_taken <= items_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && !take_break()) begin
          next_item = pending_items.pop_front();
          cur_item     <= next_item;
          mode_i       <= next_item.mode;
          key_value_i  <= next_item.key;
          is_null_i    <= next_item.is_null;
          row_index_i  <= next_item.row;
          prior_flag_i <= next_item.prior;
          last_row_i   <= next_item.last;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver and scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {row_index_out_o, passed_o, flag_out_o, slot_o, kept_total_o, last_out_o,
               set_full_o};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with nothing expected: row=%h pass=%b", got.row_index, got.passed);
        end else begin
          want = expected_results.pop_front();
          if (got.row_index !== want.row_index || got.passed !== want.passed ||
              got.flag !== want.flag || got.slot !== want.slot ||
              got.kept_total !== want.kept_total || got.last !== want.last ||
              got.set_full !== want.set_full) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch exp: row=%h pass=%b flag=%b slot=%h kept=%h last=%b full=%b",
                       want.row_index, want.passed, want.flag, want.slot, want.kept_total,
                       want.last, want.set_full);
              $display("         got: row=%h pass=%b flag=%b slot=%h kept=%h last=%b full=%b",
                       got.row_index, got.passed, got.flag, got.slot, got.kept_total,
                       got.last, got.set_full);
            end
          end
        end
      end
      // one long hold-off with the sender still busy, so the block backs up
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && items_taken >= HOLDOFF_AT && pending_items.size() > 20) begin
        holdoff_left <= HOLDOFF_LEN;
        holdoff_done <= 1'b1;
      end
      out_stall_i <= (holdoff_left != 0) || take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (rst_ni === 1'b1);
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_item(input logic [1:0] mode, input logic [63:0] key, input logic is_null,
                           input logic [ROW_W-1:0] row, input logic prior, input logic last);
    row_item_t it;
    it = {mode, key, is_null, row, prior, last};
    pending_items.push_back(it);
  endtask

  function automatic logic [63:0] fresh_key();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic list_kind, input logic negate, input logic [1:0] comb);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LIST_KIND;
    cfg_data_i  <= {1'b0, list_kind};
    @(posedge clk_i);
    cfg_index_i <= REG_NEGATE;
    cfg_data_i  <= {1'b0, negate};
    @(posedge clk_i);
    cfg_index_i <= REG_COMBINE_MODE;
    cfg_data_i  <= comb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_list_kind = list_kind;
    cfg_negate    = negate;
    cfg_comb      = comb;
  endtask

  // Mostly set build-up followed by row lookups; some clears, junk items and near-miss keys.
  task automatic queue_mixed_phase(input int count);
    int made;
    int pick;
    logic [63:0] key;
    made = 0;
    if ($urandom_range(1) == 0) begin
      push_item(ITEM_CLEAR, fresh_key(), 1'($urandom_range(1)), ROW_W'($urandom),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      key_pool.delete();
      made++;
    end
    repeat ($urandom_range(20)) begin
      key = (key_pool.size() != 0 && $urandom_range(99) < 20) ? pool_key() : fresh_key();
      push_item(ITEM_ADD, key, 1'($urandom_range(1)), ROW_W'($urandom), 1'($urandom_range(1)),
                1'($urandom_range(1)));
      key_pool.push_back(key);
      made++;
    end
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        push_item(ITEM_CLEAR, fresh_key(), 1'($urandom_range(1)), ROW_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        key_pool.delete();
        made++;
      end else if (pick < 12) begin
        key = (key_pool.size() != 0 && $urandom_range(99) < 30) ? pool_key() : fresh_key();
        push_item(ITEM_ADD, key, 1'($urandom_range(1)), ROW_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        key_pool.push_back(key);
        made++;
      end else if (pick < 16) begin
        push_item(ITEM_IGNORED, fresh_key(), 1'($urandom_range(1)), ROW_W'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (pick < 21) begin
        // add right in front of a lookup of the same key
        key = fresh_key();
        push_item(ITEM_ADD, key, 1'b0, '0, 1'b0, 1'b0);
        push_item(ITEM_EVAL, key, 1'b0, ROW_W'($urandom), 1'($urandom_range(1)), 1'b0);
        key_pool.push_back(key);
        made += 2;
      end else begin
        pick = $urandom_range(99);
        if (key_pool.size() != 0 && pick < 45)
          key = pool_key();
        else if (key_pool.size() != 0 && pick < 60)
          key = pool_key() ^ (64'd1 << $urandom_range(63));
        else
          key = fresh_key();
        push_item(ITEM_EVAL, key, $urandom_range(99) < 15, ROW_W'($urandom),
                  1'($urandom_range(1)), $urandom_range(99) < 8);
        made++;
      end
    end
  endtask

  initial begin
    for (int k = 0; k < SET_DEPTH; k++) begin
      held_key[k]   = '0;
      held_valid[k] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at reset config: IN list, no negate, compact
    push_item(ITEM_EVAL, '0, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_ADD, '0, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_ADD, '1, 1'b1, '1, 1'b1, 1'b1);
    push_item(ITEM_ADD, '0, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_EVAL, '0, 1'b0, '1, 1'b1, 1'b0);
    push_item(ITEM_EVAL, '1, 1'b1, 16'h8000, 1'b1, 1'b0);
    push_item(ITEM_EVAL, 64'h8000_0000_0000_0000, 1'b0, 16'h0001, 1'b0, 1'b1);
    for (int k = 0; k < 14; k++)
      push_item(ITEM_ADD, 64'hA5A5_0000_0000_0000 + k, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_ADD, 64'h5, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_ADD, '1, 1'b0, '0, 1'b0, 1'b0);
    push_item(ITEM_EVAL, 64'hA5A5_0000_0000_000D, 1'b0, 16'h1234, 1'b0, 1'b0);
    push_item(ITEM_IGNORED, '1, 1'b1, '1, 1'b1, 1'b1);
    push_item(ITEM_CLEAR, '1, 1'b1, '1, 1'b1, 1'b1);
    push_item(ITEM_EVAL, '0, 1'b0, 16'hFFFE, 1'b1, 1'b1);
    wait_drained();

    // Sweep every register setting, the unused combine code included
    for (int comb = 0; comb < 4; comb++) begin
      for (int kind = 0; kind < 2; kind++) begin
        for (int neg = 0; neg < 2; neg++) begin
          apply_config(kind[0], neg[0], comb[1:0]);
          @(negedge clk_i);
          queue_mixed_phase(PHASE_ITEMS);
          wait_drained();
        end
      end
    end

    // Long compact batch: empty set under negated IN list keeps every row
    apply_config(1'b0, 1'b1, COMB_COMPACT);
    @(negedge clk_i);
    push_item(ITEM_CLEAR, '0, 1'b0, '0, 1'b0, 1'b0);
    for (int n = 0; n < BATCH_ROWS; n++)
      push_item(ITEM_EVAL, fresh_key(), 1'($urandom_range(1)), ROW_W'($urandom),
                1'($urandom_range(1)), 1'b0);
    push_item(ITEM_EVAL, fresh_key(), 1'b0, '1, 1'b0, 1'b1);
    push_item(ITEM_EVAL, fresh_key(), 1'b0, '0, 1'b1, 1'b0);
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
